[rtl/rrca_pkg.sv]
// ----------------------------------------------------------------------------
// Reorder receiver package
// Widths, constants, types and helpers shared by the reorder receiver.
// ----------------------------------------------------------------------------
package rrca_pkg;

  localparam int unsigned SEQ_W        = 32;
  localparam int unsigned LEN_W        = 11;
  localparam int unsigned HANDLE_W     = 16;
  // The slot index is the low bits of the sequence number, so the window
  // size is a power of two.
  localparam int unsigned WINDOW_SLOTS = 16;
  localparam int unsigned SLOT_W       = $clog2(WINDOW_SLOTS);
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);

  localparam logic [LEN_W-1:0] HEADER_BYTES = LEN_W'(6);
  localparam logic [LEN_W-1:0] MAX_PAYLOAD  = LEN_W'(1024);
  localparam logic [SEQ_W-1:0] END_MARKER   = '1;
  localparam logic [SEQ_W-1:0] INIT_RESET   = SEQ_W'(1);

  typedef enum logic {
    KIND_ACK     = 1'b0,
    KIND_DELIVER = 1'b1
  } kind_e;

  typedef struct packed {
    logic                is_end;
    logic [SEQ_W-1:0]    seq;
    logic [HANDLE_W-1:0] handle;
    logic [LEN_W-1:0]    bytes;
  } cmd_t;

  function automatic logic [LEN_W-1:0] payload_count(input logic [LEN_W-1:0] total);
    logic [LEN_W-1:0] net;
    net = total - HEADER_BYTES;
    if (total < HEADER_BYTES) begin
      return '0;
    end else if (net > MAX_PAYLOAD) begin
      return MAX_PAYLOAD;
    end
    return net;
  endfunction

endpackage

[rtl/rrca_if.sv]
// ----------------------------------------------------------------------------
// Reorder receiver channels
// Valid/ready channels for packet descriptors in and results out.
// ----------------------------------------------------------------------------
interface rrca_in_if;
  logic                         valid;
  logic                         ready;
  logic [rrca_pkg::SEQ_W-1:0]    seq_number;
  logic [rrca_pkg::LEN_W-1:0]    total_length;
  logic [rrca_pkg::HANDLE_W-1:0] payload_handle;

  modport source (output valid, seq_number, total_length, payload_handle, input ready);
  modport sink   (input valid, seq_number, total_length, payload_handle, output ready);
endinterface

interface rrca_out_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [rrca_pkg::SEQ_W-1:0]    seq_out;
  logic [rrca_pkg::HANDLE_W-1:0] handle_out;
  logic [rrca_pkg::LEN_W-1:0]    payload_bytes;
  logic                         dropped;
  logic                         last;

  modport source (output valid, kind, seq_out, handle_out, payload_bytes, dropped, last,
                  input ready);
  modport sink   (input valid, kind, seq_out, handle_out, payload_bytes, dropped, last,
                  output ready);
endinterface

[rtl/rrca_queue.sv]
// ----------------------------------------------------------------------------
// Reorder receiver command queue
// Short first-in first-out queue of classified commands.
// ----------------------------------------------------------------------------
module rrca_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rrca_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output rrca_pkg::cmd_t head_o
);
  import rrca_pkg::*;

  cmd_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_W:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W:0] rd_ptr_q, rd_ptr_d;

  assign valid_o  = (wr_ptr_q != rd_ptr_q);
  assign full_o   = (wr_ptr_q[QPTR_W-1:0] == rd_ptr_q[QPTR_W-1:0]) &&
                    (wr_ptr_q[QPTR_W] != rd_ptr_q[QPTR_W]);
  assign head_o   = mem_q[rd_ptr_q[QPTR_W-1:0]];
  assign wr_ptr_d = (push_i && !full_o) ? wr_ptr_q + 1'b1 : wr_ptr_q;
  assign rd_ptr_d = (pop_i && valid_o) ? rd_ptr_q + 1'b1 : rd_ptr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wr_ptr_q[QPTR_W-1:0]] <= push_cmd_i;
    end
  end

endmodule

[rtl/rrca_front.sv]
// ----------------------------------------------------------------------------
// Reorder receiver front end
// Accepts packet descriptors, classifies them and feeds the command queue.
// ----------------------------------------------------------------------------
module rrca_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  rrca_in_if.sink        pkt_i,
  input  logic           q_full_i,
  output logic           push_o,
  output rrca_pkg::cmd_t push_cmd_o
);
  import rrca_pkg::*;

  logic stg_valid_q, stg_valid_d;
  cmd_t stg_q;
  logic accept;

  assign pkt_i.ready = !stg_valid_q || !q_full_i;
  assign accept      = pkt_i.valid && pkt_i.ready;
  assign push_o      = stg_valid_q && !q_full_i;
  assign push_cmd_o  = stg_q;
  assign stg_valid_d = accept || (stg_valid_q && q_full_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else begin
      stg_valid_q <= stg_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stg_q.is_end <= (pkt_i.seq_number == END_MARKER);
      stg_q.seq    <= pkt_i.seq_number;
      stg_q.handle <= pkt_i.payload_handle;
      stg_q.bytes  <= payload_count(pkt_i.total_length);
    end
  end

endmodule

[rtl/rrca_back.sv]
// ----------------------------------------------------------------------------
// Reorder receiver back end
// Owns the window state and turns each command into its result items.
// ----------------------------------------------------------------------------
module rrca_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rrca_pkg::SEQ_W-1:0] cfg_wdata_i,
  input  logic                       q_valid_i,
  input  rrca_pkg::cmd_t             q_head_i,
  output logic                       q_pop_o,
  rrca_out_if.source                 res_o
);
  import rrca_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_FLUSH
  } state_e;

  state_e                  state_q, state_d;
  logic [SEQ_W-1:0]        init_q, init_d;
  logic [SEQ_W-1:0]        expected_q, expected_d;
  logic [SEQ_W-1:0]        scan_seq_q, scan_seq_d;
  logic [WINDOW_SLOTS-1:0] valid_q, valid_d;

  logic                    out_valid_q, out_valid_d;
  kind_e                   out_kind_q, out_kind_d;
  logic [SEQ_W-1:0]        out_seq_q, out_seq_d;
  logic [HANDLE_W-1:0]     out_handle_q, out_handle_d;
  logic [LEN_W-1:0]        out_bytes_q, out_bytes_d;
  logic                    out_drop_q, out_drop_d;
  logic                    out_last_q, out_last_d;

  logic [HANDLE_W-1:0]     slot_handle_q [WINDOW_SLOTS];
  logic [LEN_W-1:0]        slot_bytes_q  [WINDOW_SLOTS];
  logic                    slot_we;
  logic [SLOT_W-1:0]       slot_wr_ix;
  logic [SLOT_W-1:0]       rd_ix;
  logic [SLOT_W-1:0]       drain_ix;
  logic [SLOT_W-1:0]       scan_ix;
  logic [HANDLE_W-1:0]     rd_handle;
  logic [LEN_W-1:0]        rd_bytes;
  logic [SEQ_W-1:0]        exp_m1;
  logic [SEQ_W-1:0]        ahead_dist;
  logic                    in_window;
  logic                    out_free;
  logic [WINDOW_SLOTS-1:0] scan_bit;

  assign drain_ix   = expected_q[SLOT_W-1:0];
  assign scan_ix    = scan_seq_q[SLOT_W-1:0];
  assign rd_ix      = (state_q == ST_FLUSH) ? scan_ix : drain_ix;
  assign rd_handle  = slot_handle_q[rd_ix];
  assign rd_bytes   = slot_bytes_q[rd_ix];
  assign exp_m1     = expected_q - 1'b1;
  assign ahead_dist = q_head_i.seq - expected_q;
  assign in_window  = (ahead_dist <= SEQ_W'(WINDOW_SLOTS));
  assign out_free   = !out_valid_q || res_o.ready;
  assign scan_bit   = WINDOW_SLOTS'(1) << scan_ix;
  assign slot_wr_ix = q_head_i.seq[SLOT_W-1:0];

  always_comb begin
    state_d      = state_q;
    init_d       = cfg_we_i ? cfg_wdata_i : init_q;
    expected_d   = expected_q;
    scan_seq_d   = scan_seq_q;
    valid_d      = valid_q;
    out_valid_d  = out_valid_q && !res_o.ready;
    out_kind_d   = out_kind_q;
    out_seq_d    = out_seq_q;
    out_handle_d = out_handle_q;
    out_bytes_d  = out_bytes_q;
    out_drop_d   = out_drop_q;
    out_last_d   = out_last_q;
    q_pop_o      = 1'b0;
    slot_we      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i && out_free) begin
          q_pop_o = 1'b1;
          if (q_head_i.is_end) begin
            if (valid_q == '0) begin
              expected_d = init_q;
            end else begin
              scan_seq_d = expected_q + 1'b1;
              state_d    = ST_FLUSH;
            end
          end else if (q_head_i.seq == expected_q) begin
            out_valid_d  = 1'b1;
            out_kind_d   = KIND_DELIVER;
            out_seq_d    = q_head_i.seq;
            out_handle_d = q_head_i.handle;
            out_bytes_d  = q_head_i.bytes;
            out_drop_d   = 1'b0;
            out_last_d   = 1'b0;
            expected_d   = expected_q + 1'b1;
            state_d      = ST_DRAIN;
          end else begin
            if ((q_head_i.seq > expected_q) && in_window) begin
              slot_we             = 1'b1;
              valid_d[slot_wr_ix] = 1'b1;
            end
            out_valid_d  = 1'b1;
            out_kind_d   = KIND_ACK;
            out_seq_d    = exp_m1;
            out_handle_d = '0;
            out_bytes_d  = '0;
            out_drop_d   = (q_head_i.seq > expected_q) && !in_window;
            out_last_d   = 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (valid_q[drain_ix]) begin
            out_kind_d        = KIND_DELIVER;
            out_seq_d         = expected_q;
            out_handle_d      = rd_handle;
            out_bytes_d       = rd_bytes;
            out_drop_d        = 1'b0;
            out_last_d        = 1'b0;
            valid_d[drain_ix] = 1'b0;
            expected_d        = expected_q + 1'b1;
          end else begin
            out_kind_d   = KIND_ACK;
            out_seq_d    = exp_m1;
            out_handle_d = '0;
            out_bytes_d  = '0;
            out_drop_d   = 1'b0;
            out_last_d   = 1'b1;
            state_d      = ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        if (valid_q == '0) begin
          expected_d = init_q;
          state_d    = ST_IDLE;
        end else if (!valid_q[scan_ix]) begin
          scan_seq_d = scan_seq_q + 1'b1;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_kind_d   = KIND_DELIVER;
          out_seq_d    = scan_seq_q;
          out_handle_d = rd_handle;
          out_bytes_d  = rd_bytes;
          out_drop_d   = 1'b0;
          out_last_d   = ((valid_q & ~scan_bit) == '0);
          valid_d      = valid_q & ~scan_bit;
          scan_seq_d   = scan_seq_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      init_q       <= INIT_RESET;
      expected_q   <= INIT_RESET;
      scan_seq_q   <= '0;
      valid_q      <= '0;
      out_valid_q  <= 1'b0;
      out_kind_q   <= KIND_ACK;
      out_seq_q    <= '0;
      out_handle_q <= '0;
      out_bytes_q  <= '0;
      out_drop_q   <= 1'b0;
      out_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      init_q       <= init_d;
      expected_q   <= expected_d;
      scan_seq_q   <= scan_seq_d;
      valid_q      <= valid_d;
      out_valid_q  <= out_valid_d;
      out_kind_q   <= out_kind_d;
      out_seq_q    <= out_seq_d;
      out_handle_q <= out_handle_d;
      out_bytes_q  <= out_bytes_d;
      out_drop_q   <= out_drop_d;
      out_last_q   <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_handle_q[slot_wr_ix] <= q_head_i.handle;
      slot_bytes_q[slot_wr_ix]  <= q_head_i.bytes;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.kind          = out_kind_q;
  assign res_o.seq_out       = out_seq_q;
  assign res_o.handle_out    = out_handle_q;
  assign res_o.payload_bytes = out_bytes_q;
  assign res_o.dropped       = out_drop_q;
  assign res_o.last          = out_last_q;

endmodule

[rtl/reorder_receiver_cumulative_ack_top.sv]
// ----------------------------------------------------------------------------
// Reorder receiver with cumulative acknowledgments
// Puts packet descriptors back in sequence order and issues acks.
// ----------------------------------------------------------------------------
// Packet descriptors enter on pkt_i and result items leave on res_o, both
// valid/ready channels. Each result item is either a delivery of a packet in
// sequence order or an ack to send; the last item of each input is marked.
// An accepted input passes through the front register and the command queue
// before the back end registers its first result. An old, duplicate,
// buffered or dropped packet yields one ack. An in-order packet is delivered,
// then each buffered packet it releases, then an ack. An end marker with
// nothing buffered yields no item; otherwise the back end delivers each
// buffered packet in sequence order. The back end runs one command at a time.
// The initial expected number is written through cfg_we_i and cfg_wdata_i
// and takes effect at the next end marker.
// Reset clears all slot valid bits and sets the expected number and the
// initial expected register to one. When the receiver stalls, the result
// register holds its item, the back end waits, the two-entry command queue
// and the front register fill, and then pkt_i.ready falls.
module reorder_receiver_cumulative_ack_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rrca_pkg::SEQ_W-1:0] cfg_wdata_i,
  rrca_in_if.sink                    pkt_i,
  rrca_out_if.source                 res_o
);
  import rrca_pkg::*;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_valid;
  cmd_t push_cmd;
  cmd_t head_cmd;

  rrca_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pkt_i      (pkt_i),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .push_cmd_o (push_cmd)
  );

  rrca_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (head_cmd)
  );

  rrca_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .q_head_i    (head_cmd),
    .q_pop_o     (q_pop),
    .res_o       (res_o)
  );

endmodule

[rtl/rrca_checker.sv]
// ----------------------------------------------------------------------------
// Reorder receiver port checker
// Checks the result channel of the reorder receiver over time.
// ----------------------------------------------------------------------------
module rrca_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          res_valid_i,
  input logic                          res_ready_i,
  input logic                          res_kind_i,
  input logic [rrca_pkg::SEQ_W-1:0]    res_seq_i,
  input logic [rrca_pkg::HANDLE_W-1:0] res_handle_i,
  input logic [rrca_pkg::LEN_W-1:0]    res_bytes_i,
  input logic                          res_dropped_i,
  input logic                          res_last_i
);
  import rrca_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_seq_i) &&
      $stable(res_kind_i) && $stable(res_last_i))
    else $error("Result item changed while stalled.");

  a_ack_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_kind_i == KIND_ACK) |-> res_last_i &&
      (res_handle_i == '0) && (res_bytes_i == '0))
    else $error("Ack item is not a plain final item.");

  a_drop_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_dropped_i |-> (res_kind_i == KIND_ACK))
    else $error("Dropped flag on a delivery.");

  a_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_kind_i == KIND_DELIVER) |-> (res_bytes_i <= MAX_PAYLOAD))
    else $error("Delivered payload count out of range.");

endmodule

bind reorder_receiver_cumulative_ack_top rrca_checker u_rrca_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .res_kind_i    (res_o.kind),
  .res_seq_i     (res_o.seq_out),
  .res_handle_i  (res_o.handle_out),
  .res_bytes_i   (res_o.payload_bytes),
  .res_dropped_i (res_o.dropped),
  .res_last_i    (res_o.last)
);
